[hdl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HCB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define HCB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/hcb_pkg.sv]
// types and constants of the huffman code builder
package hcb_pkg;

  localparam int unsigned MaxSymbolsDef = 32;
  localparam int unsigned WeightBitsDef = 16;

  typedef struct packed {
    logic [15:0] weight;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [4:0]  symbol;
    logic [30:0] code;
    logic [4:0]  code_length;
    logic        overflow;
    logic        last_out;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WR_A,
    S_WR_B,
    S_WR_N,
    S_WALK_RD,
    S_WALK_EV,
    S_EMIT
  } state_e;

endpackage

[hdl/hcb_ram.sv]
// generic single-write, single-read ram with registered read data
module hcb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/hcb_min2.sv]
// running tracker of the two lightest parentless nodes in a scan
module hcb_min2 #(
  parameter int unsigned IdxW = 6,
  parameter int unsigned WgtW = 21
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic            en_i,
  input  logic [IdxW-1:0] idx_i,
  input  logic [WgtW-1:0] wgt_i,
  output logic [IdxW-1:0] a_o,
  output logic [IdxW-1:0] b_o,
  output logic [WgtW-1:0] wa_o,
  output logic [WgtW-1:0] wb_o
);
  import hcb_pkg::*;
  `include "assert_macros.svh"

  logic            h1_q, h1_d, h2_q, h2_d;
  logic [IdxW-1:0] a_q, a_d, b_q, b_d;
  logic [WgtW-1:0] wa_q, wa_d, wb_q, wb_d;

  always_comb begin
    h1_d = h1_q;
    h2_d = h2_q;
    a_d  = a_q;
    b_d  = b_q;
    wa_d = wa_q;
    wb_d = wb_q;
    if (clr_i) begin
      h1_d = 1'b0;
      h2_d = 1'b0;
    end else if (en_i) begin
      if (!h1_q) begin
        a_d  = idx_i;
        wa_d = wgt_i;
        h1_d = 1'b1;
      end else if (wgt_i < wa_q) begin
        // strictly lighter: old minimum slides to second place
        b_d  = a_q;
        wb_d = wa_q;
        a_d  = idx_i;
        wa_d = wgt_i;
        h2_d = 1'b1;
      end else if (!h2_q || wgt_i < wb_q) begin
        b_d  = idx_i;
        wb_d = wgt_i;
        h2_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q <= 1'b0;
      h2_q <= 1'b0;
    end else begin
      h1_q <= h1_d;
      h2_q <= h2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    wa_q <= wa_d;
    wb_q <= wb_d;
  end

  assign a_o  = a_q;
  assign b_o  = b_q;
  assign wa_o = wa_q;
  assign wb_o = wb_q;

  `HCB_ASSERT_IMP(a_min2_order, h2_q, wa_q <= wb_q)
  `HCB_ASSERT_IMP(a_min2_distinct, h2_q, a_q != b_q)

endmodule

[hdl/huffman_code_builder.sv]
// huffman code builder top level: loader, merge sequencer and code walker
//
//   channel | dir | handshake              | payload
//   in      | in  | in_valid_i / in_stall_o  | hcb_pkg::in_t  (weight, last)
//   out     | out | out_valid_o / out_stall_i| hcb_pkg::out_t (symbol, code, ...)
//
// weight beats are accepted only while idle; the last beat starts the build.
// the merge that builds node i reads nodes 0 .. i-1 in turn, then drains the
// read and writes both children and node i itself, for i = n .. 2n-2.
// each code then walks leaf to root, reading each node on its path, the root included,
// and then loads the output register.
// in_stall_o is high from the last beat until the final code is loaded; a stalled
// output holds the walker. reset clears control state; the node table is not cleared.
module huffman_code_builder #(
  parameter int unsigned MaxSymbols = hcb_pkg::MaxSymbolsDef,
  parameter int unsigned WeightBits = hcb_pkg::WeightBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hcb_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hcb_pkg::out_t  out_data_o
);
  import hcb_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned Nodes = 2 * MaxSymbols - 1;
  localparam int unsigned NiW   = $clog2(Nodes);
  localparam int unsigned CntW  = $clog2(MaxSymbols + 1);
  localparam int unsigned SumW  = WeightBits + $clog2(MaxSymbols);
  localparam int unsigned EntW  = SumW + NiW + 2;
  localparam int unsigned CmpW  = NiW + 2;

  // node entry: {weight, parent, has_parent, is_right}
  logic [EntW-1:0] wdata, rdata;
  logic            we;
  logic [NiW-1:0]  waddr, raddr;

  logic [SumW-1:0] r_wgt;
  logic [NiW-1:0]  r_par;
  logic            r_hp, r_rb;
  assign {r_wgt, r_par, r_hp, r_rb} = rdata;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, n_q, n_d;
  logic            flag_q, flag_d;
  logic [NiW-1:0]  i_q, i_d, j_q, j_d, pj_q, pj_d, c_q, c_d;
  logic            rv_q, rv_d;
  logic [CntW-1:0] s_q, s_d;
  logic [NiW-1:0]  len_q, len_d;
  logic [30:0]     code_q, code_d;
  logic            ov_q, ov_d;
  out_t            out_q, out_d;

  logic            trk_clr, trk_en;
  logic [NiW-1:0]  trk_a, trk_b;
  logic [SumW-1:0] trk_wa, trk_wb;

  logic            in_acc, full, out_free, out_load;
  logic [WeightBits+15:0] w_ext;
  logic [CntW-1:0] n_new;
  logic [CmpW-1:0] i_next, i_end;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign full     = (cnt_q == CntW'(MaxSymbols));
  assign w_ext    = {{WeightBits{1'b0}}, in_data_i.weight};
  assign n_new    = full ? cnt_q : cnt_q + CntW'(1);
  assign out_free = !ov_q || !out_stall_i;
  assign out_load = (state_q == S_EMIT) && out_free;
  assign i_next   = CmpW'(i_q) + CmpW'(1);
  assign i_end    = (CmpW'(n_q) << 1) - CmpW'(1);

  hcb_ram #(.Width(EntW), .Depth(Nodes)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hcb_min2 #(.IdxW(NiW), .WgtW(SumW)) u_min2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (trk_clr),
    .en_i   (trk_en),
    .idx_i  (pj_q),
    .wgt_i  (r_wgt),
    .a_o    (trk_a),
    .b_o    (trk_b),
    .wa_o   (trk_wa),
    .wb_o   (trk_wb)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.last) begin
          state_d = (n_new < CntW'(2)) ? S_WALK_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (j_q == i_q && !rv_q) begin
          state_d = S_WR_A;
        end
      end
      S_WR_A: state_d = S_WR_B;
      S_WR_B: state_d = S_WR_N;
      S_WR_N: state_d = (i_next < i_end) ? S_SCAN : S_WALK_RD;
      S_WALK_RD: state_d = S_WALK_EV;
      S_WALK_EV: state_d = r_hp ? S_WALK_RD : S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = (s_q + CntW'(1) == n_q) ? S_IDLE : S_WALK_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d   = cnt_q;
    n_d     = n_q;
    flag_d  = flag_q;
    i_d     = i_q;
    j_d     = j_q;
    pj_d    = pj_q;
    rv_d    = 1'b0;
    c_d     = c_q;
    s_d     = s_q;
    len_d   = len_q;
    code_d  = code_q;
    out_d   = out_q;
    ov_d    = ov_q && out_stall_i;
    we      = 1'b0;
    waddr   = i_q;
    wdata   = '0;
    raddr   = c_q;
    trk_clr = 1'b0;
    trk_en  = 1'b0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (full) begin
            flag_d = 1'b1;
          end else begin
            we    = 1'b1;
            waddr = NiW'(cnt_q);
            wdata = {SumW'(w_ext[WeightBits-1:0]), NiW'(0), 1'b0, 1'b0};
            cnt_d = cnt_q + CntW'(1);
          end
          if (in_data_i.last) begin
            n_d     = n_new;
            i_d     = NiW'(n_new);
            j_d     = '0;
            trk_clr = 1'b1;
            s_d     = '0;
            c_d     = '0;
            len_d   = '0;
            code_d  = '0;
          end
        end
      end
      S_SCAN: begin
        raddr  = j_q;
        trk_en = rv_q && !r_hp;
        if (j_q != i_q) begin
          rv_d = 1'b1;
          pj_d = j_q;
          j_d  = j_q + NiW'(1);
        end
      end
      S_WR_A: begin
        we    = 1'b1;
        waddr = trk_a;
        wdata = {trk_wa, i_q, 1'b1, 1'b0};
      end
      S_WR_B: begin
        we    = 1'b1;
        waddr = trk_b;
        wdata = {trk_wb, i_q, 1'b1, 1'b1};
      end
      S_WR_N: begin
        we      = 1'b1;
        waddr   = i_q;
        wdata   = {trk_wa + trk_wb, NiW'(0), 1'b0, 1'b0};
        i_d     = i_q + NiW'(1);
        j_d     = '0;
        trk_clr = 1'b1;
      end
      S_WALK_RD: begin
        raddr = c_q;
      end
      S_WALK_EV: begin
        if (r_hp) begin
          if (r_rb && CmpW'(len_q) < CmpW'(31)) begin
            code_d = code_q | (31'(1) << len_q);
          end
          len_d = len_q + NiW'(1);
          c_d   = r_par;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d              = 1'b1;
          out_d.symbol      = 5'(s_q);
          out_d.code        = code_q;
          out_d.code_length = 5'(len_q);
          out_d.overflow    = flag_q;
          out_d.last_out    = (s_q + CntW'(1) == n_q);
          s_d    = s_q + CntW'(1);
          c_d    = NiW'(s_q + CntW'(1));
          len_d  = '0;
          code_d = '0;
          if (s_q + CntW'(1) == n_q) begin
            cnt_d  = '0;
            flag_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      flag_q  <= 1'b0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      flag_q  <= flag_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    i_q    <= i_d;
    j_q    <= j_d;
    pj_q   <= pj_d;
    c_q    <= c_d;
    s_q    <= s_d;
    len_q  <= len_d;
    code_q <= code_d;
    out_q  <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  `HCB_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_q <= CntW'(MaxSymbols))
  `HCB_ASSERT_NXT(a_final_idle, out_load && out_d.last_out, state_q == S_IDLE && cnt_q == '0)
  `HCB_ASSERT_IMP(a_scan_range, state_q == S_SCAN, CmpW'(i_q) < i_end && j_q <= i_q)
  `HCB_ASSERT_IMP(a_no_load_busy, out_load, !ov_q || !out_stall_i)

endmodule

[tb/huffman_code_builder_tb.sv]
// testbench for the huffman code builder: random weight runs checked against a tree model
module huffman_code_builder_tb;
  import hcb_pkg::*;

  localparam int unsigned MaxSym = MaxSymbolsDef;
  localparam int unsigned NodeCnt = 2 * MaxSym - 1;

  class code_scoreboard;
    out_t codes_q[$];
    longint unsigned wt[NodeCnt];
    int unsigned par[NodeCnt];
    bit has_par[NodeCnt];
    int unsigned lft[NodeCnt];
    int unsigned sym_cnt;
    bit dropped;
    int errors;

    function void note_weight(in_t beat);
      int unsigned n, lo, hi, c, len;
      logic [30:0] code;
      out_t res;
      bit h1, h2;
      if (sym_cnt < MaxSym) begin
        wt[sym_cnt] = beat.weight;
        sym_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (!beat.last) return;
      n = sym_cnt;
      for (int i = 0; i < NodeCnt; i++) has_par[i] = 1'b0;
      if (n >= 2) begin
        for (int i = n; i < 2 * n - 1; i++) begin
          h1 = 0; h2 = 0; lo = 0; hi = 0;
          for (int j = 0; j < i; j++) begin
            if (has_par[j]) continue;
            if (!h1) begin
              lo = j; h1 = 1;
            end else if (!h2) begin
              if (wt[j] < wt[lo]) begin
                hi = lo; lo = j;
              end else begin
                hi = j;
              end
              h2 = 1;
            end else if (wt[j] < wt[lo]) begin
              hi = lo; lo = j;
            end else if (wt[j] < wt[hi]) begin
              hi = j;
            end
          end
          par[lo] = i; par[hi] = i;
          has_par[lo] = 1; has_par[hi] = 1;
          lft[i] = lo;
          wt[i] = wt[lo] + wt[hi];
        end
      end
      for (int s = 0; s < n; s++) begin
        code = '0; len = 0; c = s;
        while (has_par[c]) begin
          if (lft[par[c]] != c) code[len] = 1'b1;
          len++;
          c = par[c];
        end
        res.symbol = s[4:0];
        res.code = code;
        res.code_length = len[4:0];
        res.overflow = dropped;
        res.last_out = (s + 1 == n);
        codes_q.push_back(res);
      end
      sym_cnt = 0;
      dropped = 0;
    endfunction

    function void check_code(out_t got);
      out_t exp;
      if (codes_q.size() == 0) begin
        $error("unexpected code beat symbol=%0d", got.symbol);
        errors++;
        return;
      end
      exp = codes_q.pop_front();
      if (got.symbol !== exp.symbol) begin
        $error("symbol exp %0d got %0d", exp.symbol, got.symbol); errors++;
      end
      if (got.code !== exp.code) begin
        $error("code exp %h got %h", exp.code, got.code); errors++;
      end
      if (got.code_length !== exp.code_length) begin
        $error("code_length exp %0d got %0d", exp.code_length, got.code_length); errors++;
      end
      if (got.overflow !== exp.overflow) begin
        $error("overflow exp %0d got %0d", exp.overflow, got.overflow); errors++;
      end
      if (got.last_out !== exp.last_out) begin
        $error("last_out exp %0d got %0d", exp.last_out, got.last_out); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_t in_data_i;
  out_t out_data_o;
  code_scoreboard sb;
  bit hold_rx;
  bit rx_quiet;

  huffman_code_builder dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // one weight beat, with a random gap first; valid drops after a last beat
  task automatic send_weight(logic [15:0] w, logic lst, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(8, 0) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{weight: w, last: lst};
    do @(posedge clk_i); while (in_stall_o);
    sb.note_weight(in_data_i);
    if (lst) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.codes_q.size() != 0) @(posedge clk_i);
  endtask

  // a run of n weights, random values or drawn from a narrow range for ties
  task automatic send_run(int unsigned n, int unsigned mode, bit gaps);
    logic [15:0] w;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w = 16'($urandom());
        1: w = 16'($urandom_range(3, 0));
        default: w = 16'($urandom_range(65535, 65532));
      endcase
      send_weight(w, i == n - 1, gaps);
    end
  endtask

  // receiver: random stall per beat, plus one long hold-off
  initial begin
    int unsigned gap;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(8, 0);
      if (hold_rx) begin
        gap = 3000;
        hold_rx = 0;
      end
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_code(out_data_o);
    end
  end

  initial begin
    sb = new();
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: single symbol, two symbols, extremes, ties, full table and overflow
    rx_quiet = 1;
    send_weight(16'h0000, 1'b1, 1'b0);
    send_weight(16'hffff, 1'b0, 1'b0);
    send_weight(16'h0000, 1'b1, 1'b0);
    send_weight(16'h0005, 1'b0, 1'b0);
    send_weight(16'h0005, 1'b0, 1'b0);
    send_weight(16'h0005, 1'b1, 1'b0);
    for (int i = 0; i < 34; i++) send_weight(16'h8000 >> (i % 16), i == 33, 1'b0);
    wait_drained();
    rx_quiet = 0;
    // long receiver stall while runs keep coming
    hold_rx = 1;
    send_run(8, 0, 1'b0);
    send_run(4, 1, 1'b0);
    wait_drained();
    for (int r = 0; r < 20; r++) begin
      send_run($urandom_range(6, 1), $urandom_range(2, 0), 1'b1);
      if (r % 10 == 9) send_run(32, $urandom_range(2, 0), 1'b1);
      if (r == 10) wait_drained();
    end
    send_run(36, 0, 1'b1);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.codes_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/hcb_pkg.sv
hdl/hcb_ram.sv
hdl/hcb_min2.sv
hdl/huffman_code_builder.sv
tb/huffman_code_builder_tb.sv
